### design/assert_macros.svh
// Assertion macros used by the checker file rgbte_chk.
// Depends on nothing; each use expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion with reset as disable condition
`define RGBTE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgbte: assertion failed");

// Assertion that is also checked while reset is high
`define RGBTE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rgbte: assertion failed during or after reset");

`endif

### design/rgbte_pkg.sv
// Package for the RGB5A3 tiled texture encoder: widths, register indexes, texel encoding.
// No dependencies; used by the interfaces and the core.
`timescale 1ns / 1ps

package rgbte_pkg;

   localparam int unsigned MAX_DIM_DEF = 1024;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned TEXEL_W     = 16;
   localparam int unsigned INDEX_W     = 20;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [CHAN_W-1:0]  OPAQUE_ALPHA = 8'd224;
   localparam logic [TEXEL_W-1:0] OPAQUE_BIT   = 16'h8000;
   localparam logic [4:0]         MAX_5BIT     = 5'd31;
   localparam logic [4:0]         MAX_4BIT     = 5'd15;
   localparam logic [4:0]         MAX_3BIT     = 5'd7;

   // (v*maxv + 127) / 255, the divide done as (x + (x >> 8) + 1) >> 8, exact for x < 2^16 - 1
   function automatic logic [4:0] reduce_chan(input logic [CHAN_W-1:0] v,
                                              input logic [4:0] maxv);
      logic [13:0] x;
      logic [13:0] q;
      x = 14'(v) * 14'(maxv) + 14'd127;
      q = (x + (x >> 8) + 14'd1) >> 8;
      return q[4:0];
   endfunction

   function automatic logic [TEXEL_W-1:0] encode_texel(input logic [CHAN_W-1:0] r,
                                                       input logic [CHAN_W-1:0] g,
                                                       input logic [CHAN_W-1:0] b,
                                                       input logic [CHAN_W-1:0] a);
      logic [4:0] r5, g5, b5, a3, r4, g4, b4;
      r5 = reduce_chan(r, MAX_5BIT);
      g5 = reduce_chan(g, MAX_5BIT);
      b5 = reduce_chan(b, MAX_5BIT);
      a3 = reduce_chan(a, MAX_3BIT);
      r4 = reduce_chan(r, MAX_4BIT);
      g4 = reduce_chan(g, MAX_4BIT);
      b4 = reduce_chan(b, MAX_4BIT);
      if (a >= OPAQUE_ALPHA) begin
         return OPAQUE_BIT | {1'b0, r5, g5, b5};
      end
      return {1'b0, a3[2:0], r4[3:0], g4[3:0], b4[3:0]};
   endfunction

endpackage

### design/rgbte_ifs.sv
// Valid/ready channel interfaces for pixel requests and texel responses.
// Depends on rgbte_pkg for field widths.
`timescale 1ns / 1ps

interface rgbte_req_if;
   logic                           valid;
   logic                           ready;
   logic [rgbte_pkg::CHAN_W-1:0]   red_in;
   logic [rgbte_pkg::CHAN_W-1:0]   green_in;
   logic [rgbte_pkg::CHAN_W-1:0]   blue_in;
   logic [rgbte_pkg::CHAN_W-1:0]   alpha_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   output alpha_in, input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   input alpha_in, output ready);
endinterface

interface rgbte_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rgbte_pkg::TEXEL_W-1:0]  texel_value;
   logic [rgbte_pkg::INDEX_W-1:0]  texel_index;
   logic                           last_of_pixel;
   logic                           image_done;

   modport source (output valid, output texel_value, output texel_index,
                   output last_of_pixel, output image_done, input ready);
   modport sink   (input valid, input texel_value, input texel_index,
                   input last_of_pixel, input image_done, output ready);
endinterface

### design/rgb5a3_tiled_texture_encoder_core.sv
// RGB5A3 4x4-tiled texture encoder core: raster pixels in, texels with tiled index out.
// A pixel goes through the work register and then the result register to rsp; one pixel
// per cycle for interior pixels while rsp is not stalled. Edge pixels hold the work
// register for one texel per padding copy, 1..16 copies. Reset: width and height 1,
// counters 0, pipeline empty. Depends on rgbte_pkg and rgbte_ifs.
`timescale 1ns / 1ps

module rgb5a3_tiled_texture_encoder_core #(
   parameter int unsigned MAX_DIM = rgbte_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rgbte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rgbte_pkg::CSR_DATA_W-1:0]    csr_wdata,
   rgbte_req_if.sink                           req_chan,
   rgbte_rsp_if.source                         rsp_chan
);

   localparam int unsigned PAD_MAX = ((MAX_DIM + 3) / 4) * 4;
   localparam int unsigned POS_W   = $clog2(PAD_MAX);
   localparam int unsigned DIM_W   = $clog2(PAD_MAX + 1);
   localparam int unsigned BLK_W   = rgbte_pkg::INDEX_W - 4;

   logic [DIM_W-1:0]                   width_ff, width_in, height_ff, height_in;
   logic [POS_W-1:0]                   col_ff, col_in, row_ff, row_in;

   logic                               wrk_valid_ff, wrk_valid_in;
   logic [rgbte_pkg::TEXEL_W-1:0]      wrk_texel_ff, wrk_texel_in;
   logic [POS_W-1:0]                   wrk_x_ff, wrk_x_in, wrk_y_ff, wrk_y_in;
   logic [POS_W-1:0]                   wrk_x0_ff, wrk_x0_in;
   logic [POS_W-1:0]                   wrk_xlast_ff, wrk_xlast_in, wrk_ylast_ff, wrk_ylast_in;
   logic                               wrk_img_last_ff, wrk_img_last_in;

   logic                               out_valid_ff, out_valid_in;
   logic [rgbte_pkg::TEXEL_W-1:0]      out_texel_ff, out_texel_in;
   logic [rgbte_pkg::INDEX_W-1:0]      out_index_ff, out_index_in;
   logic                               out_last_ff, out_last_in;
   logic                               out_done_ff, out_done_in;

   logic [DIM_W:0]                     pad_w_sum, pad_h_sum;
   logic [DIM_W-1:0]                   pad_w, pad_h;
   logic [POS_W-1:0]                   w_m1, h_m1, pad_w_m1, pad_h_m1;
   logic                               col_is_last, row_is_last;
   logic                               accept, out_load, wrk_final;
   logic [DIM_W-1:0]                   csr_dim;
   logic [BLK_W-1:0]                   blk;

   // Dimension clamp: zero reads as 1, oversized as MAX_DIM
   always_comb begin
      priority if (csr_wdata == '0) begin
         csr_dim = DIM_W'(1);
      end else if (csr_wdata > rgbte_pkg::CSR_DATA_W'(MAX_DIM)) begin
         csr_dim = DIM_W'(MAX_DIM);
      end else begin
         csr_dim = DIM_W'(csr_wdata);
      end
   end

   assign pad_w_sum   = ({1'b0, width_ff} + (DIM_W + 1)'(3)) & ~(DIM_W + 1)'(3);
   assign pad_h_sum   = ({1'b0, height_ff} + (DIM_W + 1)'(3)) & ~(DIM_W + 1)'(3);
   assign pad_w       = pad_w_sum[DIM_W-1:0];
   assign pad_h       = pad_h_sum[DIM_W-1:0];
   assign w_m1        = POS_W'(width_ff - DIM_W'(1));
   assign h_m1        = POS_W'(height_ff - DIM_W'(1));
   assign pad_w_m1    = POS_W'(pad_w - DIM_W'(1));
   assign pad_h_m1    = POS_W'(pad_h - DIM_W'(1));
   assign col_is_last = (col_ff == w_m1);
   assign row_is_last = (row_ff == h_m1);

   assign wrk_final   = (wrk_x_ff == wrk_xlast_ff) && (wrk_y_ff == wrk_ylast_ff);
   assign out_load    = wrk_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !wrk_valid_ff || (out_load && wrk_final);
   assign accept      = req_chan.valid && req_chan.ready;

   assign blk = BLK_W'(wrk_y_ff >> 2) * BLK_W'(pad_w >> 2) + BLK_W'(wrk_x_ff >> 2);

   // Configuration and raster counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         unique case (csr_index)
            rgbte_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_dim;
               col_in   = '0;
               row_in   = '0;
            end
            rgbte_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_dim;
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_is_last) begin
            col_in = '0;
            row_in = row_is_last ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   // Work register: current pixel and its walk over padding positions
   always_comb begin
      wrk_valid_in    = wrk_valid_ff;
      wrk_texel_in    = wrk_texel_ff;
      wrk_x_in        = wrk_x_ff;
      wrk_y_in        = wrk_y_ff;
      wrk_x0_in       = wrk_x0_ff;
      wrk_xlast_in    = wrk_xlast_ff;
      wrk_ylast_in    = wrk_ylast_ff;
      wrk_img_last_in = wrk_img_last_ff;
      if (accept) begin
         wrk_valid_in    = 1'b1;
         wrk_texel_in    = rgbte_pkg::encode_texel(req_chan.red_in, req_chan.green_in,
                                                   req_chan.blue_in, req_chan.alpha_in);
         wrk_x_in        = col_ff;
         wrk_y_in        = row_ff;
         wrk_x0_in       = col_ff;
         wrk_xlast_in    = col_is_last ? pad_w_m1 : col_ff;
         wrk_ylast_in    = row_is_last ? pad_h_m1 : row_ff;
         wrk_img_last_in = col_is_last && row_is_last;
      end else if (out_load) begin
         if (wrk_final) begin
            wrk_valid_in = 1'b0;
         end else if (wrk_x_ff == wrk_xlast_ff) begin
            wrk_x_in = wrk_x0_ff;
            wrk_y_in = wrk_y_ff + POS_W'(1);
         end else begin
            wrk_x_in = wrk_x_ff + POS_W'(1);
         end
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_texel_in = out_texel_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_texel_in = wrk_texel_ff;
         out_index_in = {blk, wrk_y_ff[1:0], wrk_x_ff[1:0]};
         out_last_in  = wrk_final;
         out_done_in  = wrk_final && wrk_img_last_ff;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_W'(1);
         height_ff    <= DIM_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         wrk_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wrk_valid_ff <= wrk_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wrk_texel_ff    <= wrk_texel_in;
      wrk_x_ff        <= wrk_x_in;
      wrk_y_ff        <= wrk_y_in;
      wrk_x0_ff       <= wrk_x0_in;
      wrk_xlast_ff    <= wrk_xlast_in;
      wrk_ylast_ff    <= wrk_ylast_in;
      wrk_img_last_ff <= wrk_img_last_in;
      out_texel_ff    <= out_texel_in;
      out_index_ff    <= out_index_in;
      out_last_ff     <= out_last_in;
      out_done_ff     <= out_done_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.texel_value   = out_texel_ff;
   assign rsp_chan.texel_index   = out_index_ff;
   assign rsp_chan.last_of_pixel = out_last_ff;
   assign rsp_chan.image_done    = out_done_ff;

endmodule

### design/rgbte_chk.sv
// Port-level checker for the encoder core, attached by bind.
// Depends on assert_macros.svh and rgbte_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgbte_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [rgbte_pkg::TEXEL_W-1:0]        rsp_texel_value,
   input logic                                 rsp_last_of_pixel,
   input logic                                 rsp_image_done
);

   // held response transaction keeps its valid and texel
   `RGBTE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_texel_value))
   `RGBTE_ASSERT(a_done_is_last, clock, reset, rsp_valid && rsp_image_done |-> rsp_last_of_pixel)
   `RGBTE_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, reset |=> !rsp_valid)
   `RGBTE_ASSERT_ALWAYS(a_req_ready_after_reset, clock, reset |=> req_ready)
   // an idle request side sees no stall source once the pipe drains
   `RGBTE_ASSERT(a_ready_when_drained, clock, reset, !req_valid && !rsp_valid && $past(!rsp_valid) && $past(!req_valid) && $past(req_ready) |-> req_ready)

endmodule

bind rgb5a3_tiled_texture_encoder_core rgbte_chk u_rgbte_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_texel_value   (rsp_chan.texel_value),
   .rsp_last_of_pixel (rsp_chan.last_of_pixel),
   .rsp_image_done    (rsp_chan.image_done)
);
